/* rtl/core/text_line_buffer_editor_top_defines.svh */
// Assertion macros for the text line buffer editor.
// Used by text_line_buffer_editor_top.sv; expects clk and rst_n in scope.
`ifndef TEXT_LINE_BUFFER_EDITOR_TOP_DEFINES_SVH
`define TEXT_LINE_BUFFER_EDITOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define TLBE_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TLBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tlbe_pkg.sv */
// Shared types and constants for the text line buffer editor.
// No dependencies; imported by tlbe_alu and the top level.
package tlbe_pkg;

    // Field widths of the request and result items
    localparam int CMD_W      = 3;
    localparam int CODE_W     = 8;
    localparam int RROW_W     = 5;
    localparam int RCOL_W     = 7;
    localparam int OCOL_W     = 7;
    localparam int OROW_W     = 5;
    localparam int OLEN_W     = 7;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    // Editor commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_BACKSPACE = 3'd1,
        CMD_NEWLINE   = 3'd2,
        CMD_LEFT      = 3'd3,
        CMD_RIGHT     = 3'd4,
        CMD_UP        = 3'd5,
        CMD_DOWN      = 3'd6,
        CMD_READ      = 3'd7
    } cmd_e_t;

    // Operations of the shared step unit
    typedef enum logic [1:0] {
        ALU_INC_A = 2'd0,
        ALU_DEC_A = 2'd1,
        ALU_DEC_B = 2'd2
    } alu_op_t;

endpackage

/* rtl/core/tlbe_alu.sv */
// Shared step unit: one increment/decrement adder and one magnitude compare.
// Depends on tlbe_pkg for the operation codes.
module tlbe_alu #(
    parameter int W = 8
) (
    input  tlbe_pkg::alu_op_t op,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output logic [W-1:0]      res,
    output logic              lt
);
    import tlbe_pkg::*;

    // Step one operand up or down by one
    always_comb
    begin
        unique case (op)
            ALU_INC_A: res = a + W'(1);
            ALU_DEC_A: res = a - W'(1);
            ALU_DEC_B: res = b - W'(1);
            default:   res = a;
        endcase
    end

    // Compare the two operands
    assign lt = (a < b);

endmodule

/* rtl/core/tlbe_char_ram.sv */
// Character cell store: one write port, one registered read port.
// No package dependency; contents are undefined until written.
module tlbe_char_ram #(
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [7:0] mem [DEPTH];

    // Write one cell
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read cell
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/tlbe_len_ram.sv */
// Row length store with per-row valid bits so that every row reads zero after reset.
// No package dependency; one write port, one registered read port.
module tlbe_len_ram #(
    parameter int ROW_W = 5,
    parameter int LEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [ROW_W-1:0] wr_addr,
    input  logic [LEN_W-1:0] wr_data,
    input  logic [ROW_W-1:0] rd_addr,
    output logic [LEN_W-1:0] rd_data
);
    localparam int DEPTH = 1 << ROW_W;

    logic [LEN_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    // Mark rows written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Write and read the lengths; an unwritten row reads as zero
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

endmodule

/* rtl/core/text_line_buffer_editor_top.sv */
// Top level of the text line buffer editor: command sequencer, cell and length stores.
// Depends on tlbe_pkg, tlbe_alu, tlbe_char_ram, tlbe_len_ram and the defines header.
//
//  Channel  | Dir | Signals                    | Contents
//  ---------+-----+----------------------------+----------------------------------------
//  s_*      | in  | s_tvalid s_tready s_tdata  | one command request
//  m_*      | out | m_tvalid m_tready m_tdata  | one result per command
//
// An insert or backspace moves each cell between the cursor and the row end, one cell moved
// per cycle through the single cell store port pair. s_tready is high only while the
// sequencer is idle. A finished result waits in the output register; the next request is
// taken meanwhile and is held at its last step until the register is free. Reset clears
// cursor, lengths and handshakes at once; the cell store is not cleared.
`include "text_line_buffer_editor_top_defines.svh"

module text_line_buffer_editor_top #(
    parameter int NUM_ROWS  = 32,
    parameter int ROW_CELLS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit up: cmd[2:0], char_code[10:3], read_row[15:11],
    // read_col[22:16], zero pad[23]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit up: cursor_col[6:0], cursor_row[11:7], row_length[18:12],
    // read_char[26:19], took_effect[27], zero pad[31:28]
    output logic [31:0] m_tdata
);
    import tlbe_pkg::*;

    localparam int ROW_W   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int COL_W   = $clog2(ROW_CELLS);
    localparam int CA_W    = ROW_W + COL_W;
    localparam int AW0     = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int AW      = (AW0 > RCOL_W) ? AW0 : RCOL_W;
    localparam int MAX_LEN = ROW_CELLS - 1;
    localparam int LAST_ROW = NUM_ROWS - 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_INS_SHIFT,
        S_INS_PUT,
        S_INS_LEN,
        S_BS_SHIFT,
        S_BS_LEN,
        S_CLAMP,
        S_RD_CHK,
        S_FINISH
    } state_t;

    state_t              state_reg;
    cmd_e_t              cmd_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [RROW_W-1:0]   rrow_reg;
    logic [RCOL_W-1:0]   rcol_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    cur_len_reg;
    logic [COL_W-1:0]    idx_reg;
    logic [COL_W-1:0]    dst_reg;
    logic                pend_reg;
    logic [COL_W-1:0]    pend_addr_reg;
    logic [7:0]          rchar_reg;
    logic                effect_reg;
    logic                out_valid_reg;
    logic [OCOL_W-1:0]   out_col_reg;
    logic [OROW_W-1:0]   out_row_reg;
    logic [OLEN_W-1:0]   out_len_reg;
    logic [7:0]          out_char_reg;
    logic                out_effect_reg;

    alu_op_t             alu_op;
    logic [AW-1:0]       alu_a;
    logic [AW-1:0]       alu_b;
    logic [AW-1:0]       alu_res;
    logic                alu_lt;

    logic                cw_en;
    logic [CA_W-1:0]     cw_addr;
    logic [7:0]          cw_data;
    logic [CA_W-1:0]     cr_addr;
    logic [7:0]          cr_data;

    logic                lw_en;
    logic [COL_W-1:0]    lw_data;
    logic [ROW_W-1:0]    lr_addr;
    logic [COL_W-1:0]    lr_data;

    logic                rrow_ok;
    logic [31:0]         col_ext;
    logic [31:0]         row_ext;
    logic [31:0]         len_ext;

    tlbe_alu #(.W(AW)) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .lt  (alu_lt)
    );

    tlbe_char_ram #(.ADDR_W(CA_W)) u_char_ram (
        .clk     (clk),
        .wr_en   (cw_en),
        .wr_addr (cw_addr),
        .wr_data (cw_data),
        .rd_addr (cr_addr),
        .rd_data (cr_data)
    );

    tlbe_len_ram #(.ROW_W(ROW_W), .LEN_W(COL_W)) u_len_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (lw_en),
        .wr_addr (row_reg),
        .wr_data (lw_data),
        .rd_addr (lr_addr),
        .rd_data (lr_data)
    );

    assign rrow_ok = (32'(rrow_reg) < NUM_ROWS);

    // Steer the shared step unit for the current step
    always_comb
    begin
        alu_op = ALU_INC_A;
        alu_a  = AW'(col_reg);
        alu_b  = AW'(cur_len_reg);
        unique case (state_reg)
            S_DISP:
            begin
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        alu_a = AW'(cur_len_reg);
                        alu_b = AW'(MAX_LEN);
                    end
                    CMD_BACKSPACE, CMD_LEFT:
                    begin
                        alu_op = ALU_DEC_A;
                    end
                    CMD_NEWLINE, CMD_DOWN:
                    begin
                        alu_a = AW'(row_reg);
                        alu_b = AW'(LAST_ROW);
                    end
                    CMD_UP:
                    begin
                        alu_op = ALU_DEC_A;
                        alu_a  = AW'(row_reg);
                    end
                    CMD_RIGHT, CMD_READ:
                    begin
                        alu_op = ALU_INC_A;
                    end
                endcase
            end
            S_INS_SHIFT:
            begin
                alu_op = ALU_DEC_B;
                alu_b  = AW'(idx_reg);
            end
            S_INS_LEN:
            begin
                alu_a = AW'(cur_len_reg);
            end
            S_BS_SHIFT:
            begin
                alu_a = AW'(idx_reg);
            end
            S_BS_LEN:
            begin
                alu_op = ALU_DEC_A;
                alu_a  = AW'(cur_len_reg);
            end
            S_CLAMP:
            begin
                alu_a = AW'(lr_data);
                alu_b = AW'(col_reg);
            end
            S_RD_CHK:
            begin
                alu_a = AW'(rcol_reg);
                alu_b = AW'(lr_data);
            end
            default:
            begin
                alu_op = ALU_INC_A;
            end
        endcase
    end

    // Drive the cell store: a delayed shift write has priority over the new character
    always_comb
    begin
        cw_en   = 1'b0;
        cw_addr = {row_reg, col_reg};
        cw_data = code_reg;
        if (pend_reg)
        begin
            cw_en   = 1'b1;
            cw_addr = {row_reg, pend_addr_reg};
            cw_data = cr_data;
        end
        else if (state_reg == S_INS_PUT)
        begin
            cw_en = 1'b1;
        end

        priority if (state_reg == S_INS_SHIFT)
        begin
            cr_addr = {row_reg, COL_W'(alu_res)};
        end
        else if (state_reg == S_BS_SHIFT)
        begin
            cr_addr = {row_reg, idx_reg};
        end
        else
        begin
            cr_addr = {ROW_W'(rrow_reg), COL_W'(rcol_reg)};
        end
    end

    // Drive the length store
    always_comb
    begin
        lw_en   = (state_reg == S_INS_LEN) || (state_reg == S_BS_LEN);
        lw_data = COL_W'(alu_res);
        lr_addr = (cmd_reg == CMD_READ) ? ROW_W'(rrow_reg) : ROW_W'(alu_res);
    end

    assign col_ext = 32'(col_reg);
    assign row_ext = 32'(row_reg);
    assign len_ext = 32'(cur_len_reg);

    // Sequencer: state, cursor, shift pointers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_READ;
            code_reg       <= '0;
            rrow_reg       <= '0;
            rcol_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            cur_len_reg    <= '0;
            idx_reg        <= '0;
            dst_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            rchar_reg      <= '0;
            effect_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_len_reg    <= '0;
            out_char_reg   <= '0;
            out_effect_reg <= 1'b0;
        end
        else
        begin
            // Drop the result once taken, unless a new one replaces it
            if (out_valid_reg && m_tready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    // Take a new request
                    if (s_tvalid)
                    begin
                        cmd_reg    <= cmd_e_t'(s_tdata[2:0]);
                        code_reg   <= s_tdata[10:3];
                        rrow_reg   <= s_tdata[15:11];
                        rcol_reg   <= s_tdata[22:16];
                        rchar_reg  <= '0;
                        effect_reg <= 1'b0;
                        state_reg  <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if ((code_reg != '0) && alu_lt)
                            begin
                                idx_reg    <= cur_len_reg;
                                effect_reg <= 1'b1;
                                state_reg  <= S_INS_SHIFT;
                            end
                            else
                            begin
                                state_reg <= S_FINISH;
                            end
                        end
                        CMD_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                col_reg    <= COL_W'(alu_res);
                                dst_reg    <= COL_W'(alu_res);
                                idx_reg    <= col_reg;
                                effect_reg <= 1'b1;
                                state_reg  <= S_BS_SHIFT;
                            end
                            else
                            begin
                                state_reg <= S_FINISH;
                            end
                        end
                        CMD_NEWLINE:
                        begin
                            if (alu_lt)
                            begin
                                row_reg    <= ROW_W'(alu_res);
                                col_reg    <= '0;
                                effect_reg <= 1'b1;
                                state_reg  <= S_CLAMP;
                            end
                            else
                            begin
                                state_reg <= S_FINISH;
                            end
                        end
                        CMD_DOWN:
                        begin
                            if (alu_lt)
                            begin
                                row_reg    <= ROW_W'(alu_res);
                                effect_reg <= 1'b1;
                                state_reg  <= S_CLAMP;
                            end
                            else
                            begin
                                state_reg <= S_FINISH;
                            end
                        end
                        CMD_UP:
                        begin
                            if (row_reg != '0)
                            begin
                                row_reg    <= ROW_W'(alu_res);
                                effect_reg <= 1'b1;
                                state_reg  <= S_CLAMP;
                            end
                            else
                            begin
                                state_reg <= S_FINISH;
                            end
                        end
                        CMD_LEFT:
                        begin
                            state_reg <= S_FINISH;
                            if (col_reg != '0)
                            begin
                                col_reg    <= COL_W'(alu_res);
                                effect_reg <= 1'b1;
                            end
                        end
                        CMD_RIGHT:
                        begin
                            state_reg <= S_FINISH;
                            if (alu_lt)
                            begin
                                col_reg    <= COL_W'(alu_res);
                                effect_reg <= 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            state_reg <= S_RD_CHK;
                        end
                    endcase
                end
                S_INS_SHIFT:
                begin
                    // Move one cell right, from the row end down to the cursor
                    pend_reg <= alu_lt;
                    if (alu_lt)
                    begin
                        pend_addr_reg <= idx_reg;
                        idx_reg       <= COL_W'(alu_res);
                    end
                    else
                    begin
                        state_reg <= S_INS_PUT;
                    end
                end
                S_INS_PUT:
                begin
                    // Place the character and advance the cursor
                    col_reg   <= COL_W'(alu_res);
                    state_reg <= S_INS_LEN;
                end
                S_INS_LEN:
                begin
                    cur_len_reg <= COL_W'(alu_res);
                    state_reg   <= S_FINISH;
                end
                S_BS_SHIFT:
                begin
                    // Move one cell left, from the old cursor up to the row end
                    pend_reg <= alu_lt;
                    if (alu_lt)
                    begin
                        pend_addr_reg <= dst_reg;
                        dst_reg       <= idx_reg;
                        idx_reg       <= COL_W'(alu_res);
                    end
                    else
                    begin
                        state_reg <= S_BS_LEN;
                    end
                end
                S_BS_LEN:
                begin
                    cur_len_reg <= COL_W'(alu_res);
                    state_reg   <= S_FINISH;
                end
                S_CLAMP:
                begin
                    // Take the new row's length and clamp the column to it
                    cur_len_reg <= lr_data;
                    if (alu_lt)
                    begin
                        col_reg <= lr_data;
                    end
                    state_reg <= S_FINISH;
                end
                S_RD_CHK:
                begin
                    // Return the cell only below the row's length
                    if (rrow_ok && alu_lt)
                    begin
                        rchar_reg <= cr_data;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    // Hold until the result register is free
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_col_reg    <= col_ext[OCOL_W-1:0];
                        out_row_reg    <= row_ext[OROW_W-1:0];
                        out_len_reg    <= len_ext[OLEN_W-1:0];
                        out_char_reg   <= rchar_reg;
                        out_effect_reg <= effect_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_effect_reg, out_char_reg, out_len_reg,
                       out_row_reg, out_col_reg};

    // Checks on the sequencer
    `TLBE_ASSERT_HOLDS(a_idle_no_pending, s_tready, !pend_reg, "shift write left pending")
    `TLBE_ASSERT_HOLDS(a_col_in_row, s_tready, col_reg <= cur_len_reg, "cursor past row end")
    `TLBE_ASSERT_HOLDS(a_row_in_range, s_tready, 32'(row_reg) < NUM_ROWS, "cursor row range")
    `TLBE_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "ready after take")

endmodule
